FILE: hdl/skf_pkg.sv
// Shared types and constants for the scalar Kalman filter step unit.
`default_nettype none

package skf_pkg;

   // Widths of the configuration port
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATE_GAIN       = 2'd0,
      CSR_MEASURE_GAIN     = 2'd1,
      CSR_PROCESS_VARIANCE = 2'd2,
      CSR_MEASURE_VARIANCE = 2'd3
   } csr_index_type;

   // Sequencer states: each multiply has an issue (_M) and a writeback (_W) state
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_XP_M,   ST_XP_W,
      ST_T1_M,   ST_T1_W,
      ST_T2_M,   ST_T2_W,
      ST_CP_M,   ST_CP_W,
      ST_T3_M,   ST_T3_W,
      ST_DIV_INIT,
      ST_DIV_RUN,
      ST_DIV_FIN,
      ST_T4_M,   ST_T4_W,
      ST_T5_M,   ST_T5_W,
      ST_KC_M,   ST_KC_W,
      ST_P_M,    ST_P_W,
      ST_DONE
   } state_type;

   // Divider produces this many quotient bits, MSB first
   localparam int unsigned QUOT_W = 34;

endpackage

`default_nettype wire

FILE: hdl/scalar_kalman_filter_step_unit.sv
// Scalar Kalman filter step: shared 33x33 multiplier and serial divider under a sequencer.
// The serial divider is skipped when the gain denominator is zero.
// A request is taken only while the sequencer is idle; the gain uses a 34-step restoring divider.
// The result register lets the next request start while a result still waits on rsp_stall.
// Reset (synchronous, active high): estimate and variance to zero, config to A=1.2, C=1,
// R=1, Q=2 in fixed point, sequencer idle, no result pending.
`default_nettype none

module scalar_kalman_filter_step_unit
   import skf_pkg::*;
#(
   parameter int unsigned FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic signed [31:0]    req_measurement,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [31:0]         rsp_estimate,
   output logic [30:0]                rsp_variance,
   output logic signed [31:0]         rsp_gain,
   output logic                       rsp_singular,
   // configuration write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // Fixed-point constants derived from FRAC_BITS
   localparam longint ONE_L   = 64'sd1 << FRAC_BITS;
   localparam longint A_RST_L = (12 * ONE_L + 5) / 10;
   localparam longint Q_RST_L = (2 * ONE_L > 64'sd2147483647) ? 64'sd2147483647 : 2 * ONE_L;
   localparam logic signed [31:0] SG_RST = 32'(A_RST_L);
   localparam logic signed [31:0] MG_RST = 32'(ONE_L);
   localparam logic [30:0]        PV_RST = 31'(ONE_L);
   localparam logic [30:0]        MV_RST = 31'(Q_RST_L);
   localparam logic signed [32:0] ONE_33 = 33'(ONE_L);
   localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [65:0] MAX32_W = 66'sd2147483647;
   localparam logic signed [65:0] MIN32_W = -66'sd2147483648;
   localparam logic signed [31:0] MAX32  = 32'sh7fffffff;
   localparam logic signed [31:0] MIN32  = 32'sh80000000;
   localparam logic [30:0]        MAXVAR = 31'h7fffffff;
   localparam logic [5:0]         DIV_LAST = 6'(QUOT_W - 1);

   // Saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32_f(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > MAX32_W) begin
         r = MAX32;
      end else if (v < MIN32_W) begin
         r = MIN32;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Saturate to the variance range 0 .. 2^31-1
   function automatic logic [30:0] satvar_f(input logic signed [65:0] v);
      logic [30:0] r;
      if (v > MAX32_W) begin
         r = MAXVAR;
      end else if (v < 66'sd0) begin
         r = 31'd0;
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

   // Sequencer
   state_type state_ff, state_in;

   // Configuration registers
   logic signed [31:0] sg_ff, mg_ff;
   logic [30:0]        pv_ff, mv_ff;

   // Filter state
   logic signed [31:0] est_ff, est_in;
   logic [30:0]        var_ff, var_in;

   // Working registers
   logic signed [31:0] z_ff, z_in;
   logic signed [31:0] xp_ff, xp_in;
   logic [30:0]        pp_ff, pp_in;
   logic signed [31:0] cp_ff, cp_in;
   logic signed [33:0] den_ff, den_in;
   logic signed [31:0] t_ff, t_in;
   logic signed [31:0] k_ff, k_in;
   logic               sing_ff, sing_in;
   logic signed [31:0] innov_ff, innov_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [32:0] omk_ff, omk_in;
   logic [30:0]        p_ff, p_in;

   // Divider registers
   logic [65:0]        rem_ff, rem_in;
   logic [65:0]        dsh_ff, dsh_in;
   logic [QUOT_W-1:0]  quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               qneg_ff, qneg_in;

   // Shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] product_ff, product_in;
   logic signed [65:0] round_val;
   logic signed [31:0] rq32;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_est_ff, rsp_est_in;
   logic [30:0]        rsp_var_ff, rsp_var_in;
   logic signed [31:0] rsp_gain_ff, rsp_gain_in;
   logic               rsp_sing_ff, rsp_sing_in;

   // Helpers
   logic               req_take;
   logic               rsp_free;
   logic signed [33:0] sum34;
   logic signed [32:0] sum33;
   logic [32:0]        dmag;
   logic [31:0]        cmag;
   logic               div_ge;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Handshake outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      csr_ready = 1'b1;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_variance = rsp_var_ff;
   assign rsp_gain     = rsp_gain_ff;
   assign rsp_singular = rsp_sing_ff;

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_XP_M: begin
            mul_a = {sg_ff[31], sg_ff};
            mul_b = {est_ff[31], est_ff};
         end
         ST_T1_M: begin
            mul_a = {sg_ff[31], sg_ff};
            mul_b = {2'b00, var_ff};
         end
         ST_T2_M: begin
            mul_a = {t_ff[31], t_ff};
            mul_b = {sg_ff[31], sg_ff};
         end
         ST_CP_M: begin
            mul_a = {mg_ff[31], mg_ff};
            mul_b = {2'b00, pp_ff};
         end
         ST_T3_M: begin
            mul_a = {mg_ff[31], mg_ff};
            mul_b = {cp_ff[31], cp_ff};
         end
         ST_T4_M: begin
            mul_a = {mg_ff[31], mg_ff};
            mul_b = {xp_ff[31], xp_ff};
         end
         ST_T5_M: begin
            mul_a = {k_ff[31], k_ff};
            mul_b = {innov_ff[31], innov_ff};
         end
         ST_KC_M: begin
            mul_a = {k_ff[31], k_ff};
            mul_b = {mg_ff[31], mg_ff};
         end
         ST_P_M: begin
            mul_a = omk_ff;
            mul_b = {2'b00, pp_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product_in = mul_a * mul_b;

   // Round half up and drop the fraction bits
   assign round_val = (product_ff + HALF) >>> FRAC_BITS;
   assign rq32      = sat32_f(round_val);

   // Divider compare and operand magnitudes
   assign div_ge = (rem_ff >= dsh_ff);
   assign dmag   = den_ff[33] ? 33'(-den_ff) : den_ff[32:0];
   assign cmag   = cp_ff[31] ? 32'(-cp_ff) : cp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_take) state_in = ST_XP_M;
         ST_XP_M:     state_in = ST_XP_W;
         ST_XP_W:     state_in = ST_T1_M;
         ST_T1_M:     state_in = ST_T1_W;
         ST_T1_W:     state_in = ST_T2_M;
         ST_T2_M:     state_in = ST_T2_W;
         ST_T2_W:     state_in = ST_CP_M;
         ST_CP_M:     state_in = ST_CP_W;
         ST_CP_W:     state_in = ST_T3_M;
         ST_T3_M:     state_in = ST_T3_W;
         ST_T3_W:     state_in = ST_DIV_INIT;
         ST_DIV_INIT: state_in = (den_ff == 34'sd0) ? ST_T4_M : ST_DIV_RUN;
         ST_DIV_RUN:  if (cnt_ff == 6'd0) state_in = ST_DIV_FIN;
         ST_DIV_FIN:  state_in = ST_T4_M;
         ST_T4_M:     state_in = ST_T4_W;
         ST_T4_W:     state_in = ST_T5_M;
         ST_T5_M:     state_in = ST_T5_W;
         ST_T5_W:     state_in = ST_KC_M;
         ST_KC_M:     state_in = ST_KC_W;
         ST_KC_W:     state_in = ST_P_M;
         ST_P_M:      state_in = ST_P_W;
         ST_P_W:      state_in = ST_DONE;
         ST_DONE:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and result register updates
   always_comb begin
      z_in     = z_ff;
      xp_in    = xp_ff;
      pp_in    = pp_ff;
      cp_in    = cp_ff;
      den_in   = den_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      sing_in  = sing_ff;
      innov_in = innov_ff;
      x_in     = x_ff;
      omk_in   = omk_ff;
      p_in     = p_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      qneg_in  = qneg_ff;
      est_in   = est_ff;
      var_in   = var_ff;
      sum34    = '0;
      sum33    = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_est_in   = rsp_est_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_gain_in  = rsp_gain_ff;
      rsp_sing_in  = rsp_sing_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) z_in = req_measurement;
         end
         ST_XP_W: xp_in = rq32;
         ST_T1_W: t_in  = rq32;
         ST_T2_W: begin
            // predicted variance: (A*P)*A + R
            sum34 = {{2{rq32[31]}}, rq32} + {3'b000, pv_ff};
            pp_in = satvar_f({{32{sum34[33]}}, sum34});
         end
         ST_CP_W: cp_in = rq32;
         ST_T3_W: begin
            den_in = {{2{rq32[31]}}, rq32} + {3'b000, mv_ff};
         end
         ST_DIV_INIT: begin
            sing_in = (den_ff == 34'sd0);
            k_in    = '0;
            rem_in  = {34'd0, cmag} << FRAC_BITS;
            dsh_in  = {dmag, 33'd0};
            quo_in  = '0;
            cnt_in  = DIV_LAST;
            qneg_in = cp_ff[31] ^ den_ff[33];
         end
         ST_DIV_RUN: begin
            // one restoring step per cycle, quotient MSB first
            if (div_ge) rem_in = rem_ff - dsh_ff;
            dsh_in = dsh_ff >> 1;
            quo_in = {quo_ff[QUOT_W-2:0], div_ge};
            cnt_in = cnt_ff - 6'd1;
         end
         ST_DIV_FIN: begin
            if (!qneg_ff) begin
               k_in = (quo_ff[33:31] != 3'd0) ? MAX32 : {1'b0, quo_ff[30:0]};
            end else if (quo_ff[33:32] != 2'd0 || (quo_ff[31] && quo_ff[30:0] != 31'd0)) begin
               k_in = MIN32;
            end else begin
               k_in = -signed'(quo_ff[31:0]);
            end
         end
         ST_T4_W: begin
            // innovation z - C*x'
            sum33    = {z_ff[31], z_ff} - {rq32[31], rq32};
            innov_in = sat32_f({{33{sum33[32]}}, sum33});
         end
         ST_T5_W: begin
            sum33 = {xp_ff[31], xp_ff} + {rq32[31], rq32};
            x_in  = sat32_f({{33{sum33[32]}}, sum33});
         end
         ST_KC_W: omk_in = ONE_33 - {rq32[31], rq32};
         ST_P_W:  p_in   = satvar_f(round_val);
         ST_DONE: begin
            if (rsp_free) begin
               est_in       = x_ff;
               var_in       = p_ff;
               rsp_valid_in = 1'b1;
               rsp_est_in   = x_ff;
               rsp_var_in   = p_ff;
               rsp_gain_in  = k_ff;
               rsp_sing_in  = sing_ff;
            end
         end
         default: begin
            z_in = z_ff;
         end
      endcase
   end

   // Control state, configuration and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sg_ff        <= SG_RST;
         mg_ff        <= MG_RST;
         pv_ff        <= PV_RST;
         mv_ff        <= MV_RST;
         est_ff       <= '0;
         var_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         est_ff       <= est_in;
         var_ff       <= var_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_STATE_GAIN:       sg_ff <= csr_wdata;
               CSR_MEASURE_GAIN:     mg_ff <= csr_wdata;
               CSR_PROCESS_VARIANCE: pv_ff <= csr_wdata[30:0];
               CSR_MEASURE_VARIANCE: mv_ff <= csr_wdata[30:0];
               default:              sg_ff <= sg_ff;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      product_ff  <= product_in;
      z_ff        <= z_in;
      xp_ff       <= xp_in;
      pp_ff       <= pp_in;
      cp_ff       <= cp_in;
      den_ff      <= den_in;
      t_ff        <= t_in;
      k_ff        <= k_in;
      sing_ff     <= sing_in;
      innov_ff    <= innov_in;
      x_ff        <= x_in;
      omk_ff      <= omk_in;
      p_ff        <= p_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      qneg_ff     <= qneg_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_var_ff  <= rsp_var_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_sing_ff <= rsp_sing_in;
   end

   // A new result only appears out of the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

   // A singular step always reports a zero gain
   a_sing_zero_gain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sing_ff) |-> (rsp_gain_ff == 32'sd0))
      else $error("singular result with nonzero gain");

   // The divider leaves after its last quotient bit
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_RUN && cnt_ff == 6'd0) |=> (state_ff == ST_DIV_FIN))
      else $error("divider did not finish on its last step");

   // A finished step waits while the held result is stalled
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_DONE))
      else $error("completion overran a stalled result");

endmodule

`default_nettype wire
